// File: hw/rtl/mtag_pkg.sv
// Package for the memory tag access guard.
// Holds tag, privilege and command codes, the item and decision types, and the allow matrix.
// No dependencies.
package mtag_pkg;

	localparam int IdxW       = 10;
	localparam int TagEntries = 1 << IdxW;
	localparam int TagW       = 2;

	typedef logic [IdxW-1:0] idx_t;
	typedef logic [TagW-1:0] tag_t;

	localparam logic [1:0] CmdRead  = 2'd0;
	localparam logic [1:0] CmdWrite = 2'd1;
	localparam logic [1:0] CmdCheck = 2'd2;

	localparam tag_t TagN  = 2'd0;
	localparam tag_t TagC  = 2'd1;
	localparam tag_t TagUt = 2'd2;
	localparam tag_t TagSt = 2'd3;

	localparam logic [1:0] PrvUser    = 2'd0;
	localparam logic [1:0] PrvSuper   = 2'd1;
	localparam logic [1:0] PrvMachine = 2'd3;

	localparam logic [1:0] KindLoad  = 2'd0;
	localparam logic [1:0] KindStore = 2'd1;
	localparam logic [1:0] KindFetch = 2'd2;

	localparam logic [2:0] AllowL = 3'b001;
	localparam logic [2:0] AllowS = 3'b010;
	localparam logic [2:0] AllowF = 3'b100;

	// Captured fields of one transaction.
	typedef struct packed {
		logic [1:0] cmd;
		idx_t       idx;
		tag_t       val;
		logic [1:0] kind;
		logic [1:0] prv;
		logic       enforce;
		logic       utrun;
	} item_t;

	// Decision from the rule logic.
	typedef struct packed {
		tag_t rd_tag;
		logic fault;
		logic wr_en;
		logic sec_next;
	} dec_t;

	// Allowed access kinds for mode {secure, supervisor} and tag.
	function automatic logic [2:0] allow_mask(input logic [1:0] mode, input tag_t tag);
		logic [2:0] m;
		m = 3'b000;
		case (mode)
			2'd0, 2'd1: begin
				case (tag)
					TagN:    m = AllowL | AllowS | AllowF;
					TagC:    m = AllowF;
					default: m = 3'b000;
				endcase
			end
			2'd2: begin
				case (tag)
					TagN:    m = AllowL | AllowS | AllowF;
					TagC:    m = AllowL | AllowF;
					TagUt:   m = AllowL | AllowS | AllowF;
					default: m = 3'b000;
				endcase
			end
			default: begin
				case (tag)
					TagUt:   m = AllowL | AllowS;
					default: m = AllowL | AllowS | AllowF;
				endcase
			end
		endcase
		return m;
	endfunction

endpackage

// File: hw/rtl/mtag_ram.sv
// Tag store: one synchronous write port, one registered read port with write bypass.
// Depends on mtag_pkg.
module mtag_ram (
	input  logic           clk,
	input  logic           we,
	input  mtag_pkg::idx_t waddr,
	input  mtag_pkg::tag_t wdata,
	input  logic           re,
	input  mtag_pkg::idx_t raddr,
	output mtag_pkg::tag_t rdata
);

	mtag_pkg::tag_t mem [mtag_pkg::TagEntries];
	mtag_pkg::tag_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Forward a write landing on the same entry in the same cycle.
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && waddr == raddr) begin
				rdata_q <= wdata;
			end else begin
				rdata_q <= mem[raddr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/mtag_rules.sv
// Write rules and access check for one transaction against the stored tag.
// Depends on mtag_pkg.
module mtag_rules (
	input  mtag_pkg::item_t item,
	input  mtag_pkg::tag_t  old_tag,
	input  logic            secure,
	output mtag_pkg::dec_t  dec
);

	logic       guarded;
	logic       old_user_ok;
	logic       val_user_ok;
	logic [1:0] mode;
	logic [2:0] mask;
	logic       allowed;

	always_comb begin
		guarded     = item.enforce && (item.prv != mtag_pkg::PrvMachine);
		old_user_ok = (old_tag == mtag_pkg::TagN) || (old_tag == mtag_pkg::TagUt);
		val_user_ok = (item.val == mtag_pkg::TagN) || (item.val == mtag_pkg::TagUt);
		mode        = {secure, item.prv == mtag_pkg::PrvSuper};
		mask        = mtag_pkg::allow_mask(mode, old_tag);
		case (item.kind)
			mtag_pkg::KindLoad:  allowed = mask[0];
			mtag_pkg::KindStore: allowed = mask[1];
			mtag_pkg::KindFetch: allowed = mask[2];
			default:             allowed = 1'b0;
		endcase

		dec.rd_tag   = '0;
		dec.fault    = 1'b0;
		dec.wr_en    = 1'b0;
		dec.sec_next = secure;

		case (item.cmd)
			mtag_pkg::CmdRead: begin
				dec.rd_tag = old_tag;
			end
			mtag_pkg::CmdWrite: begin
				if (guarded && !secure &&
				    (old_tag != mtag_pkg::TagN || item.val != mtag_pkg::TagN)) begin
					dec.fault = 1'b1;
				end
				if (guarded && item.prv == mtag_pkg::PrvUser && !(old_user_ok && val_user_ok)) begin
					dec.fault = 1'b1;
				end
				dec.wr_en = !dec.fault;
			end
			mtag_pkg::CmdCheck: begin
				if (guarded) begin
					if (!allowed) begin
						dec.fault = 1'b1;
					end else if (item.kind == mtag_pkg::KindFetch) begin
						if (!secure) begin
							if (old_tag == mtag_pkg::TagC) begin
								if (item.prv == mtag_pkg::PrvUser && !item.utrun) begin
									dec.fault = 1'b1;
								end else begin
									dec.sec_next = 1'b1;
								end
							end
						end else if (old_tag == mtag_pkg::TagN) begin
							dec.sec_next = 1'b0;
						end
					end
				end
			end
			default: begin
				dec.rd_tag = '0;
			end
		endcase
	end

endmodule

// File: hw/rtl/memory_tag_access_guard.sv
// Memory tag access guard: tag store with write rules, access check and secure level flag.
// After reset, busy stays high while the clear sweep writes every tag to
// normal; then one transaction is taken per cycle. Each transaction reads its tag from the
// store in the accept cycle, is decided and written back in the next, and its result is
// shown on the cycle after that with done high for one cycle. A write followed at once by
// an access to the same granule sees the new tag through a bypass on the store's read
// port. The result cannot be stalled.
// Depends on mtag_pkg, mtag_ram, mtag_rules.
module memory_tag_access_guard (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] cmd,
	input  logic [9:0] granule_index,
	input  logic [1:0] tag_value,
	input  logic [1:0] access_kind,
	input  logic [1:0] privilege,
	input  logic       enforce_active,
	input  logic       ut_runnable,
	output logic       done,
	output logic [1:0] tag_read,
	output logic       fault,
	output logic       secure_now
);

	logic            clearing_q;
	mtag_pkg::idx_t  clr_idx_q;
	logic            accept;
	logic            valid_s1;
	mtag_pkg::item_t item_s1;
	mtag_pkg::tag_t  old_tag;
	mtag_pkg::dec_t  dec;
	logic            secure_q;
	logic            done_q;
	mtag_pkg::tag_t  tag_read_q;
	logic            fault_q;
	logic            we;
	mtag_pkg::idx_t  waddr;
	mtag_pkg::tag_t  wdata;

	assign busy   = clearing_q;
	assign accept = start && !busy;

	// Clear sweep after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == mtag_pkg::idx_t'(mtag_pkg::TagEntries - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (clearing_q) begin
			we    = 1'b1;
			waddr = clr_idx_q;
			wdata = mtag_pkg::TagN;
		end else begin
			we    = valid_s1 && dec.wr_en;
			waddr = item_s1.idx;
			wdata = item_s1.val;
		end
	end

	mtag_ram u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (accept),
		.raddr (granule_index),
		.rdata (old_tag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.cmd     <= cmd;
			item_s1.idx     <= granule_index;
			item_s1.val     <= tag_value;
			item_s1.kind    <= access_kind;
			item_s1.prv     <= privilege;
			item_s1.enforce <= enforce_active;
			item_s1.utrun   <= ut_runnable;
		end
	end

	mtag_rules u_rules (
		.item    (item_s1),
		.old_tag (old_tag),
		.secure  (secure_q),
		.dec     (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			secure_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= valid_s1;
			if (valid_s1) begin
				secure_q <= dec.sec_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			tag_read_q <= dec.rd_tag;
			fault_q    <= dec.fault;
		end
	end

	assign done       = done_q;
	assign tag_read   = tag_read_q;
	assign fault      = fault_q;
	assign secure_now = secure_q;

`ifndef SYNTHESIS
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("accepted transaction produced no result");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> !done)
		else $error("result without a transaction");
	a_no_item_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !valid_s1)
		else $error("transaction in flight during clear sweep");
	a_secure_only_on_check: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && item_s1.cmd == mtag_pkg::CmdCheck) |=> $stable(secure_q))
		else $error("secure level changed outside a check");
	a_write_not_fault: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !(dec.wr_en && dec.fault))
		else $error("faulting write updates the store");
`endif

endmodule
